// File: rtl/mbp_pkg.sv
// ============================================================================
// mbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ============================================================================
package mbp_pkg;

    // operation codes carried in s_axis_tuser[1:0]
    localparam logic [1:0] OP_BITS  = 2'd0;
    localparam logic [1:0] OP_BYTES = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned NBITS_W = 7;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned CAP_W   = 24;
    localparam int unsigned SR_W    = VALUE_W + 8;   // one pending byte plus the value
    localparam int unsigned NBYTE_W = 4;             // up to nine bytes per item
    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned IN_TUSER_W  = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET = 24'd65536;
    localparam logic [BCNT_W-1:0] MAX_BYTES = 4'd8;
    localparam logic [NBITS_W-1:0] MAX_BITS = 7'd64;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture an accepted item
        logic emit;   // move the next byte into the output register
        logic last;   // the byte being emitted is the item's final one
    } cmd_t;

endpackage

// File: rtl/mbp_ctrl.sv
// ============================================================================
// mbp_ctrl
// Controller: accepts items, counts out the bytes each one produces and
// owns the output valid flag.
// ============================================================================
module mbp_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mbp_pkg::NBYTE_W-1:0]    load_nbytes,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mbp_pkg::cmd_t                  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                        state_reg, state_next;
    logic [mbp_pkg::NBYTE_W-1:0] cnt_reg, cnt_next;
    logic                        ovalid_reg, ovalid_next;
    logic                        slot_free;

    assign slot_free = !ovalid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = ovalid_reg;

    // command decode
    always_comb
    begin
        cmd.load = s_valid && (state_reg == ST_IDLE);
        cmd.emit = (state_reg == ST_EMIT) && slot_free;
        cmd.last = (cnt_reg == mbp_pkg::NBYTE_W'(1));
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : ovalid_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && (load_nbytes != '0))
                begin
                    state_next = ST_EMIT;
                    cnt_next   = load_nbytes;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit)
                begin
                    cnt_next = cnt_reg - mbp_pkg::NBYTE_W'(1);
                    if (cmd.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// File: rtl/mbp_dp.sv
// ============================================================================
// mbp_dp
// Datapath: pending bits, byte shift register, emitted-byte counter,
// capacity register and the output byte register.
// ============================================================================
module mbp_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mbp_pkg::cmd_t                     cmd,
    input  logic [1:0]                        op,
    input  logic [mbp_pkg::VALUE_W-1:0]       value,
    input  logic [mbp_pkg::NBITS_W-1:0]       bit_width,
    input  logic [mbp_pkg::BCNT_W-1:0]        byte_count,
    input  logic                              little_endian,
    input  logic                              cfg_wr_en,
    input  logic [mbp_pkg::CAP_W-1:0]         cfg_wr_data,
    output logic [mbp_pkg::NBYTE_W-1:0]       load_nbytes,
    output logic [7:0]                        out_byte,
    output logic                              out_overflow,
    output logic                              out_last
);

    localparam int unsigned SR_W = mbp_pkg::SR_W;

    logic [7:0]                 pend_reg;      // pending bits, left aligned
    logic [2:0]                 pcount_reg;
    logic [SR_W-1:0]            sr_reg;
    logic [mbp_pkg::CAP_W-1:0]  emitted_reg;
    logic [mbp_pkg::CAP_W-1:0]  cap_reg;
    logic [7:0]                 obyte_reg;
    logic                       oovf_reg;
    logic                       olast_reg;

    logic [7:0]                 pend_eff;
    logic                       has_pend;
    logic                       bits_ok;
    logic [mbp_pkg::NBITS_W-1:0] vshift;
    logic [mbp_pkg::VALUE_W-1:0] vleft;
    logic [mbp_pkg::NBITS_W-1:0] total;
    logic [SR_W-1:0]            sr_bits;
    logic [mbp_pkg::BCNT_W-1:0] bc_sat;
    logic [mbp_pkg::VALUE_W-1:0] be_left;
    logic [mbp_pkg::VALUE_W-1:0] le_data;
    logic [mbp_pkg::VALUE_W-1:0] bytes_data;
    logic [SR_W-1:0]            sr_load;
    logic [2:0]                 pcount_load;
    logic                       ovf;

    assign has_pend = (pcount_reg != 3'd0);
    assign pend_eff = has_pend ? pend_reg : 8'd0;

    // bit write: new bits placed right behind the pending ones
    assign bits_ok = (bit_width <= mbp_pkg::MAX_BITS);
    assign vshift  = mbp_pkg::MAX_BITS - bit_width;
    assign vleft   = value << vshift;
    assign total   = mbp_pkg::NBITS_W'(pcount_reg) + bit_width;
    assign sr_bits = {pend_eff, {mbp_pkg::VALUE_W{1'b0}}} | ({vleft, 8'd0} >> pcount_reg);

    // aligned byte write: left-aligned bytes in send order
    assign bc_sat  = (byte_count > mbp_pkg::MAX_BYTES) ? mbp_pkg::MAX_BYTES : byte_count;
    assign be_left = value << {mbp_pkg::MAX_BYTES - bc_sat, 3'b000};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            le_data[(7-i)*8 +: 8] = value[i*8 +: 8];
    end

    assign bytes_data = little_endian ? le_data : be_left;

    // load decode per operation
    always_comb
    begin
        sr_load     = {pend_eff, {mbp_pkg::VALUE_W{1'b0}}};
        pcount_load = pcount_reg;
        load_nbytes = '0;
        case (op)
            mbp_pkg::OP_BITS:
            begin
                if (bits_ok)
                begin
                    sr_load     = sr_bits;
                    pcount_load = total[2:0];
                    load_nbytes = total[6:3];
                end
            end
            mbp_pkg::OP_BYTES:
            begin
                sr_load     = has_pend ? {pend_eff, bytes_data} : {bytes_data, 8'd0};
                pcount_load = 3'd0;
                load_nbytes = bc_sat + mbp_pkg::NBYTE_W'(has_pend);
            end
            mbp_pkg::OP_FLUSH:
            begin
                pcount_load = 3'd0;
                load_nbytes = mbp_pkg::NBYTE_W'(has_pend);
            end
            default:
            begin
                load_nbytes = '0;
            end
        endcase
    end

    assign ovf = (emitted_reg >= cap_reg);

    // shift register and output byte (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sr_reg <= sr_load;
        else if (cmd.emit)
            sr_reg <= {sr_reg[SR_W-9:0], 8'd0};
        if (cmd.emit)
        begin
            obyte_reg <= sr_reg[SR_W-1 -: 8];
            oovf_reg  <= ovf;
            olast_reg <= cmd.last;
        end
    end

    // packer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            pcount_reg  <= '0;
            emitted_reg <= '0;
            cap_reg     <= mbp_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (cmd.load)
            begin
                pcount_reg <= pcount_load;
                if (load_nbytes == '0)
                    pend_reg <= sr_load[SR_W-1 -: 8];
            end
            else if (cmd.emit)
            begin
                // after the final byte the top byte is the leftover bits
                pend_reg <= sr_reg[SR_W-9 -: 8];
                if (!ovf)
                    emitted_reg <= emitted_reg + mbp_pkg::CAP_W'(1);
            end
        end
    end

    assign out_byte     = obyte_reg;
    assign out_overflow = oovf_reg;
    assign out_last     = olast_reg;

endmodule

// File: rtl/msb_first_bit_packer.sv
// ============================================================================
// msb_first_bit_packer
// Packs variable-width fields MSB first into a byte stream.
// ============================================================================
// An item is accepted while the controller is idle and then produces 0 to 9
// output bytes; the byte shift register delivers one byte per cycle into the
// output register, and a stalled output holds the controller in its emit state.
// Items that produce no byte (no bits completed, flush with nothing pending,
// ignored codes) leave the controller idle. Each byte carries an overflow flag
// in m_axis_tuser when the emitted-byte counter has reached cfg capacity; that
// byte is still shown but not counted. tlast marks the final byte of each item.
// Capacity may be written only while idle.
module msb_first_bit_packer
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // value[63:0], bit_width[70:64], byte_count[74:71]
    input  logic [2:0]  s_axis_tuser,   // op[1:0], little_endian[2]
    // output bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic [0:0]  m_axis_tuser,   // overflow[0]
    output logic        m_axis_tlast,
    // capacity register
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data
);

    mbp_pkg::cmd_t               cmd;
    logic [mbp_pkg::NBYTE_W-1:0] load_nbytes;

    mbp_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .load_nbytes (load_nbytes),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .cmd         (cmd)
    );

    mbp_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (s_axis_tuser[1:0]),
        .value         (s_axis_tdata[63:0]),
        .bit_width     (s_axis_tdata[70:64]),
        .byte_count    (s_axis_tdata[74:71]),
        .little_endian (s_axis_tuser[2]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .load_nbytes   (load_nbytes),
        .out_byte      (m_axis_tdata),
        .out_overflow  (m_axis_tuser[0]),
        .out_last      (m_axis_tlast)
    );

endmodule

// File: bench/msb_first_bit_packer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// msb_first_bit_packer_test
// Self-checking bench for the MSB-first bit packer. A driver and a receiver
// toggle their handshakes at random; every accepted item goes through a
// behavioral packer that queues the bytes it should produce, and every
// accepted output byte is compared against the oldest queued byte. Phases
// walk the capacity register through its reset value, both extremes, a limit
// crossed mid-phase and a limit dropped below the byte counter.
// ============================================================================
module msb_first_bit_packer_test;

    localparam logic [1:0] OP_UNUSED   = 2'd3;    // reserved code, must be ignored
    localparam int         HALF_PERIOD = 10;
    localparam int         SETTLE      = 12;
    localparam int         RX_HOLD     = 150;     // long receiver stall
    localparam int         STUCK_LIMIT = 2000;    // cycles with no handshake at all

    typedef struct packed {
        logic [1:0]                  op;
        logic [mbp_pkg::VALUE_W-1:0] value;
        logic [mbp_pkg::NBITS_W-1:0] nbits;
        logic [mbp_pkg::BCNT_W-1:0]  bcnt;
        logic                        le;
    } pack_req_t;

    typedef struct {
        logic [7:0] data;
        logic       ovf;
        logic       last;
    } out_byte_t;

    // DUT ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en     = 1'b0;
    logic [23:0] cfg_wr_data   = '0;

    // stimulus bookkeeping
    pack_req_t   req_queue[$];
    pack_req_t   tx_req;
    logic        in_taken      = 1'b0;
    int          n_queued      = 0;
    int          n_taken       = 0;
    logic        calm          = 1'b0;
    int          rx_hold_asked = 0;
    int          rx_hold_given = 0;
    int          rx_hold_left  = 0;
    int          stuck_cycles  = 0;
    int          failures      = 0;

    // packer state mirror
    logic [7:0]                pend_bits  = '0;
    int unsigned               pend_cnt   = 0;
    logic [mbp_pkg::CAP_W-1:0] sent_bytes = '0;
    logic [mbp_pkg::CAP_W-1:0] capacity   = mbp_pkg::CAP_RESET;
    out_byte_t                 item_bytes[$];
    out_byte_t                 bytes_due[$];

    msb_first_bit_packer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral packer
    // ------------------------------------------------------------------------

    // a completed byte; past capacity it is flagged and not counted
    task automatic record_byte(input logic [7:0] b);
        out_byte_t ob;
        ob.data = b;
        ob.ovf  = (sent_bytes >= capacity);
        ob.last = 1'b0;
        if (!ob.ovf)
            sent_bytes = sent_bytes + 1'b1;
        item_bytes.push_back(ob);
    endtask

    // zero-pad and emit a partial byte, if any
    task automatic pad_partial();
        if (pend_cnt != 0)
        begin
            record_byte(pend_bits << (8 - pend_cnt));
            pend_bits = '0;
            pend_cnt  = 0;
        end
    endtask

    task automatic pack_item(input pack_req_t r);
        int n_bytes;
        int idx;
        item_bytes.delete();
        case (r.op)
            mbp_pkg::OP_BITS:
            begin
                // widths above 64 are dropped without effect
                if (r.nbits <= mbp_pkg::MAX_BITS)
                begin
                    for (int i = r.nbits; i > 0; i--)
                    begin
                        pend_bits = {pend_bits[6:0], r.value[i-1]};
                        pend_cnt++;
                        if (pend_cnt == 8)
                        begin
                            record_byte(pend_bits);
                            pend_bits = '0;
                            pend_cnt  = 0;
                        end
                    end
                end
            end
            mbp_pkg::OP_BYTES:
            begin
                pad_partial();
                n_bytes = (r.bcnt > mbp_pkg::MAX_BYTES) ? mbp_pkg::MAX_BYTES : r.bcnt;
                for (int i = 0; i < n_bytes; i++)
                begin
                    idx = r.le ? i : (n_bytes - 1 - i);
                    record_byte(r.value[idx*8 +: 8]);
                end
            end
            mbp_pkg::OP_FLUSH:
                pad_partial();
            default:
                ;
        endcase
        if (item_bytes.size() != 0)
            item_bytes[item_bytes.size()-1].last = 1'b1;
        foreach (item_bytes[i])
            bytes_due.push_back(item_bytes[i]);
    endtask

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic pack_req_t make_req(input logic [1:0] op, input logic [63:0] value,
                                           input int nbits, input int bcnt, input logic le);
        pack_req_t r;
        r.op    = op;
        r.value = value;
        r.nbits = nbits[mbp_pkg::NBITS_W-1:0];
        r.bcnt  = bcnt[mbp_pkg::BCNT_W-1:0];
        r.le    = le;
        return r;
    endfunction

    function automatic pack_req_t rand_req();
        pack_req_t r;
        int        pick;
        r.value = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5)
            r.value = '0;
        else if (pick < 10)
            r.value = '1;
        r.le   = 1'($urandom_range(1));
        r.bcnt = mbp_pkg::BCNT_W'($urandom_range(15));
        r.nbits = mbp_pkg::NBITS_W'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            r.op = mbp_pkg::OP_BITS;
            pick = $urandom_range(99);
            if (pick < 8)
                r.nbits = '0;
            else if (pick < 16)
                r.nbits = mbp_pkg::MAX_BITS;
            else if (pick >= 22)
                r.nbits = mbp_pkg::NBITS_W'($urandom_range(63, 1));
        end
        else if (pick < 75)
        begin
            r.op = mbp_pkg::OP_BYTES;
            if ($urandom_range(99) >= 25)
                r.bcnt = mbp_pkg::BCNT_W'($urandom_range(8, 1));
        end
        else if (pick < 90)
            r.op = mbp_pkg::OP_FLUSH;
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    // queue random items until the given number of effective ones is in
    task automatic queue_random(input int count);
        pack_req_t r;
        int        useful;
        useful = 0;
        while (useful < count)
        begin
            r = rand_req();
            req_queue.push_back(r);
            n_queued++;
            if (r.op != OP_UNUSED &&
                !(r.op == mbp_pkg::OP_BITS && r.nbits > mbp_pkg::MAX_BITS))
                useful++;
        end
    endtask

    task automatic queue_req(input pack_req_t r);
        req_queue.push_back(r);
        n_queued++;
    endtask

    // wait until every item is taken and every byte has come out
    task automatic wait_drained();
        while (req_queue.size() != 0 || n_taken != n_queued || bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [mbp_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        capacity     = cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: a new item only once the previous one was taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (req_queue.size() != 0 && (calm || $urandom_range(99) >= 29))
            begin
                tx_req         = req_queue.pop_front();
                s_axis_tdata  <= {5'b0, tx_req.bcnt, tx_req.nbits, tx_req.value};
                s_axis_tuser  <= {tx_req.le, tx_req.op};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: random backpressure plus requested long holds
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end
        else if (rx_hold_asked != rx_hold_given)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= RX_HOLD;
            rx_hold_given <= rx_hold_given + 1;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end

    // ------------------------------------------------------------------------
    // Prediction on input handshakes, checking on output handshakes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pack_item(tx_req);
                n_taken++;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected byte %02h", m_axis_tdata);
                    failures++;
                end
                else
                begin
                    out_byte_t want;
                    want = bytes_due.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
                        failures++;
                    end
                    if (m_axis_tuser[0] !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, m_axis_tuser[0]);
                        failures++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        failures++;
                    end
                end
            end

            // watchdog on handshake activity
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("msb_first_bit_packer test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed items at the reset capacity
        queue_req(make_req(mbp_pkg::OP_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 64, 0, 1'b0)); // full
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h0, 0, 0, 1'b0));                    // zero
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h5, 3, 0, 1'b0));                    // partial
        queue_req(make_req(mbp_pkg::OP_FLUSH, 64'h0, 0, 0, 1'b0));                    // padded
        queue_req(make_req(mbp_pkg::OP_FLUSH, 64'h0, 0, 0, 1'b0));                    // empty
        queue_req(make_req(mbp_pkg::OP_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 65, 0, 1'b1)); // ignored
        queue_req(make_req(mbp_pkg::OP_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 127, 15, 1'b1));
        queue_req(make_req(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8, 8, 1'b1));          // reserved
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h1B, 5, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'h0123_4567_89AB_CDEF, 0, 8, 1'b0));  // pad + 8
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h3, 2, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'h0, 0, 0, 1'b0));                    // pad only
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'h0, 0, 0, 1'b1));                    // nothing
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'hFEDC_BA98_7654_3210, 0, 15, 1'b1)); // saturated
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'hA5, 0, 1, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BYTES, 64'h5A, 0, 1, 1'b1));
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h7F, 7, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h0, 1, 0, 1'b0));                    // completes
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h6, 3, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h8000_0000_0000_0001, 64, 0, 1'b0)); // unaligned
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h0, 64, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_BITS,  64'h1, 1, 0, 1'b0));
        queue_req(make_req(mbp_pkg::OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 127, 15, 1'b1));
        wait_drained();

        // top capacity; the receiver stalls while the sender keeps going
        write_capacity('1);
        @(posedge clk);
        queue_random(35);
        rx_hold_asked++;
        wait_drained();

        // zero capacity, no idling on either side
        write_capacity('0);
        @(posedge clk);
        calm = 1'b1;
        queue_random(20);
        wait_drained();
        calm = 1'b0;

        // limit a little ahead of the counter, crossed within the phase
        write_capacity(mbp_pkg::CAP_W'(sent_bytes + $urandom_range(20, 5)));
        @(posedge clk);
        queue_random(30);
        rx_hold_asked++;
        wait_drained();

        // limit dropped below the counter
        write_capacity(sent_bytes >> 1);
        @(posedge clk);
        queue_random(17);
        wait_drained();

        // back to the top
        write_capacity('1);
        @(posedge clk);
        queue_random(17);
        wait_drained();

        if (failures == 0 && bytes_due.size() == 0)
            $display("msb_first_bit_packer test passed");
        else
            $display("msb_first_bit_packer test failed");
        $finish;
    end

endmodule
